// ----- rtl/core/rgb_kernel_convolution_unit_assert.svh -----
`ifndef RGB_KERNEL_CONVOLUTION_UNIT_ASSERT_SVH
`define RGB_KERNEL_CONVOLUTION_UNIT_ASSERT_SVH

// check that cond holds in the same cycle as trig
`define RKC_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("rkc check failed");

// check that cond holds in the cycle after trig
`define RKC_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("rkc check failed");

`endif

// ----- rtl/core/rkc_pkg.sv -----
`timescale 1ns / 1ps
package rkc_pkg;

  localparam int DEF_KERNEL_SIZE    = 3;
  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_COEF_FRAC_BITS = 8;

  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int TAPS    = 9;
  localparam int DIM_W   = 11;
  localparam int ROWS_W  = 48;
  localparam int ADDR_W  = 3;
  localparam int PROD_W  = PIX_W + 1 + COEF_W;
  localparam int SUM_W   = PROD_W + 4;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [ADDR_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_COEF_TOP = 3'd2;
  localparam logic [ADDR_W-1:0] REG_COEF_MID = 3'd3;
  localparam logic [ADDR_W-1:0] REG_COEF_BOT = 3'd4;

  localparam logic [0:0] OP_PIXEL = 1'b0;
  localparam logic [0:0] OP_DRAIN = 1'b1;

  typedef logic [TAPS-1:0][PIX_W-1:0]  pix9_t;
  typedef logic [TAPS-1:0][COEF_W-1:0] coef9_t;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } pipe_en_t;

endpackage

// ----- rtl/core/rkc_line_store.sv -----
`timescale 1ns / 1ps
module rkc_line_store import rkc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          sel,
  input  logic [CW-1:0] addr,
  input  logic [23:0]   wdata,
  output logic [23:0]   top,
  output logic [23:0]   mid
);

  logic [23:0] bank0 [MAX_WIDTH];
  logic [23:0] bank1 [MAX_WIDTH];
  logic [23:0] rd0_r;
  logic [23:0] rd1_r;
  logic        sel_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rd0_r <= bank0[addr];
      rd1_r <= bank1[addr];
      sel_r <= sel;
      if (sel) begin
        bank1[addr] <= wdata;
      end else begin
        bank0[addr] <= wdata;
      end
    end
  end

  assign top = sel_r ? rd1_r : rd0_r;
  assign mid = sel_r ? rd0_r : rd1_r;

endmodule

// ----- rtl/core/rkc_lane.sv -----
`timescale 1ns / 1ps
module rkc_lane import rkc_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic             clk,
  input  pipe_en_t         ctl,
  input  pix9_t            pix_i,
  input  coef9_t           coef_i,
  output logic [PIX_W-1:0] res_o
);

  logic signed [PROD_W-1:0] prod_r [TAPS];
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  shifted;
  logic [PIX_W-1:0]         res_nxt;
  logic [PIX_W-1:0]         res_r;

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      for (int t = 0; t < TAPS; t++) begin
        prod_r[t] <= PROD_W'($signed({1'b0, pix_i[t]}) * $signed(coef_i[t]));
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int t = 0; t < TAPS; t++) begin
      acc = acc + SUM_W'(prod_r[t]);
    end
    shifted = acc >>> COEF_FRAC_BITS;
    if (acc <= 0) begin
      res_nxt = '0;
    end else if (shifted > SUM_W'(PIX_MAX)) begin
      res_nxt = PIX_MAX;
    end else begin
      res_nxt = shifted[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ----- rtl/core/rgb_kernel_convolution_unit.sv -----
`timescale 1ns / 1ps
// Output: out_tvalid rises after the window and lane registers hold the item that
//   completes a window; the first image_width + 1 items of a frame give no result.
// Throughput: one item per cycle unless stalled, set by the single-port-per-bank
//   line store and the registered lane pipeline (products, then sum and clamp).
// Reset: rst_n low (synchronous) clears counters, valids, window and registers to
//   their defaults; the line store contents are not cleared.
module rgb_kernel_convolution_unit import rkc_pkg::*; #(
  parameter int KERNEL_SIZE    = DEF_KERNEL_SIZE,
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // red_in, green_in, blue_in
  input  logic [0:0]        in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // red_out, green_out, blue_out
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [ROWS_W-1:0] cfg_wdata
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = DIM_W + 1;
  localparam int HALF_K = KERNEL_SIZE / 2;

  logic [DIM_W-1:0]  img_w_r, img_h_r;
  logic [ROWS_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;
  logic [CW-1:0]     in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0]     in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [WW-1:0]     eff_w;
  logic [RW-1:0]     eff_h;

  logic        acc_in, take, done0, emit0, last0;
  logic [23:0] pix0;
  logic [8:0]  mask0;
  logic        row_up, row_dn, col_lf, col_rt;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        rdy1, rdy2, rdy3, rdy4;
  logic        emit1_r, last1_r, last2_r, last3_r, last4_r;
  logic [8:0]  mask1_r, mask2_r;
  logic [23:0] pix1_r, top1, mid1;
  logic [23:0] win_r [TAPS];
  logic [ROWS_W-1:0] rows [3];
  coef9_t      coef_m;
  pix9_t       lane_pix [3];
  logic [PIX_W-1:0] lane_res [3];
  pipe_en_t    ctl;

  always_comb begin
    if (img_w_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(img_w_r);
    end
    eff_h = (img_h_r == '0) ? RW'(1) : RW'(img_h_r);
  end

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign acc_in = in_tvalid && in_tready;

  always_comb begin
    done0  = in_row_r >= eff_h;
    take   = acc_in && !(in_tuser == OP_DRAIN && !done0);
    pix0   = done0 ? 24'd0 : {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
    emit0  = (in_row_r > RW'(1)) || (in_row_r == RW'(1) && in_col_r != '0);
    last0  = (out_row_r + RW'(1) >= eff_h) && (WW'(out_col_r) + WW'(1) >= eff_w);
    row_up = (HALF_K >= 1) && (out_row_r != '0);
    row_dn = (HALF_K >= 1) && (out_row_r + RW'(1) < eff_h);
    col_lf = (HALF_K >= 1) && (out_col_r != '0);
    col_rt = (HALF_K >= 1) && (WW'(out_col_r) + WW'(1) < eff_w);
    mask0  = {row_dn & col_rt, row_dn, row_dn & col_lf,
              col_rt, 1'b1, col_lf,
              row_up & col_rt, row_up, row_up & col_lf};

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      if (WW'(in_col_r) + WW'(1) >= eff_w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit0) begin
        if (last0) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (WW'(out_col_r) + WW'(1) >= eff_w) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= DIM_W'(1024);
      img_h_r    <= DIM_W'(1024);
      coef_top_r <= '0;
      coef_mid_r <= ROWS_W'(48'd16777216);
      coef_bot_r <= '0;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH: begin
          img_w_r <= cfg_wdata[DIM_W-1:0];
        end
        REG_HEIGHT: begin
          img_h_r <= cfg_wdata[DIM_W-1:0];
        end
        REG_COEF_TOP: coef_top_r <= cfg_wdata;
        REG_COEF_MID: coef_mid_r <= cfg_wdata;
        REG_COEF_BOT: coef_bot_r <= cfg_wdata;
        default: ;
      endcase
      if (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  rkc_line_store #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_line_store (
    .clk   (clk),
    .en    (take),
    .sel   (in_row_r[0]),
    .addr  (in_col_r),
    .wdata (pix0),
    .top   (top1),
    .mid   (mid1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int t = 0; t < TAPS; t++) begin
        win_r[t] <= '0;
      end
    end else begin
      if (rdy1) begin
        v1_r <= take;
      end
      if (rdy2) begin
        v2_r <= v1_r && emit1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (v1_r && rdy2) begin
        for (int dy = 0; dy < 3; dy++) begin
          win_r[dy*3]   <= win_r[dy*3+1];
          win_r[dy*3+1] <= win_r[dy*3+2];
        end
        win_r[2] <= top1;
        win_r[5] <= mid1;
        win_r[8] <= pix1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix1_r  <= pix0;
      emit1_r <= emit0;
      last1_r <= last0;
      mask1_r <= mask0;
    end
    if (v1_r && rdy2) begin
      last2_r <= last1_r;
      mask2_r <= mask1_r;
    end
    if (v2_r && rdy3) begin
      last3_r <= last2_r;
    end
    if (v3_r && rdy4) begin
      last4_r <= last3_r;
    end
  end

  assign rows[0] = coef_top_r;
  assign rows[1] = coef_mid_r;
  assign rows[2] = coef_bot_r;

  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        coef_m[dy*3+dx] = mask2_r[dy*3+dx] ? rows[dy][dx*COEF_W +: COEF_W] : '0;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int t = 0; t < TAPS; t++) begin
        lane_pix[ch][t] = mask2_r[t] ? win_r[t][(2-ch)*PIX_W +: PIX_W] : '0;
      end
    end
  end

  assign ctl.prod_en = v2_r && rdy3;
  assign ctl.sum_en  = v3_r && rdy4;

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    rkc_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .pix_i  (lane_pix[ch]),
      .coef_i (coef_m),
      .res_o  (lane_res[ch])
    );
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {lane_res[2], lane_res[1], lane_res[0]};
  assign out_tlast  = last4_r;

`include "rgb_kernel_convolution_unit_assert.svh"

  `RKC_ASSERT_NOW(a_ready_when_s1_empty, !v1_r, in_tready)
  `RKC_ASSERT_NEXT(a_frame_wrap, take && emit0 && last0 && !cfg_we,
                   in_row_r == '0 && in_col_r == '0 && out_row_r == '0)
  `RKC_ASSERT_NEXT(a_cfg_restart, cfg_we && cfg_addr == REG_WIDTH,
                   out_row_r == '0 && out_col_r == '0)

endmodule
